// File: rtl/sorted_list_slot_table_macros.svh
// Assertion macros for the sorted list slot table.
// Included by the top level; needs no package.
`ifndef SORTED_LIST_SLOT_TABLE_MACROS_SVH
`define SORTED_LIST_SLOT_TABLE_MACROS_SVH

// check a condition at every clock edge outside reset
`define SLST_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("slot table check failed");

// check a consequence in the same cycle
`define SLST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table check failed");

// check a consequence in the next cycle
`define SLST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table check failed");

`endif

// File: rtl/slst_pkg.sv
// Shared constants and types of the sorted list slot table.
// No dependencies; used by slst_cmp and sorted_list_slot_table.
`default_nettype none

package slst_pkg;

   localparam int DEPTH_DEF   = 32;
   localparam int KEY_W       = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int SUCC_OUT_W  = 7;
   localparam int COUNT_OUT_W = 7;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

`default_nettype wire

// File: rtl/sorted_list_slot_table.sv
// Top level of the sorted list slot table: sequencer, slot RAMs and compare unit.
// Depends on slst_pkg, slst_ram, slst_cmp and sorted_list_slot_table_macros.svh.
//
//   channel | direction | tdata                          | tuser   | tlast
//   req     | in        | key[31:0]                      | op[1:0] | -
//   rsp     | out       | entry_successor[6:0],          | status  | last
//           |           | entry_count[13:7], zero[15:14] | [1:0]   |
//
// One item at a time; req_tready is high only while the sequencer is idle.
// Each list step is a slot RAM read, then a compare in the shared unit. The walk stops
// at the first larger key, or for a delete at an equal one; a delete that frees a slot
// below the top moves the top entry into it and scans the slots below the top for its
// predecessor. Dump gives one word per occupied slot and waits on any rsp stall; a
// result waits in the output register while the next word is accepted. No clearing
// pass after reset.
`default_nettype none

module sorted_list_slot_table #(
   parameter int DEPTH = slst_pkg::DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // key[31:0]
   input  wire logic [1:0]  req_tuser,  // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // entry_successor[6:0], entry_count[13:7], zero
   output logic [1:0]       rsp_tuser,  // status[1:0]
   output logic             rsp_tlast   // last
);

   localparam int IW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int SW  = IW + 1;
   localparam int KW  = slst_pkg::KEY_W;
   localparam int SOW = slst_pkg::SUCC_OUT_W;
   localparam int COW = slst_pkg::COUNT_OUT_W;
   localparam logic [SW-1:0] END_CODE = {1'b1, {IW{1'b0}}};

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_WRD     = 4'd1;
   localparam logic [3:0] S_WCHK    = 4'd2;
   localparam logic [3:0] S_INS_WR  = 4'd3;
   localparam logic [3:0] S_INS_LNK = 4'd4;
   localparam logic [3:0] S_DEL_UNL = 4'd5;
   localparam logic [3:0] S_DEL_RDT = 4'd6;
   localparam logic [3:0] S_DEL_MOV = 4'd7;
   localparam logic [3:0] S_SC_RD   = 4'd8;
   localparam logic [3:0] S_SC_CHK  = 4'd9;
   localparam logic [3:0] S_DEL_FIN = 4'd10;
   localparam logic [3:0] S_DRD     = 4'd11;
   localparam logic [3:0] S_DOUT    = 4'd12;
   localparam logic [3:0] S_RESP    = 4'd13;

   logic [3:0]                      state_ff, state_in;
   logic [slst_pkg::OP_W-1:0]       op_ff, op_in;
   logic signed [KW-1:0]            key_ff, key_in;
   logic [SW-1:0]                   head_ff, head_in;
   logic [SW-1:0]                   cur_ff, cur_in;
   logic [SW-1:0]                   prev_ff, prev_in;
   logic [SW-1:0]                   csucc_ff, csucc_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [slst_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [SOW-1:0]                  resp_succ_ff, resp_succ_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [slst_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SOW-1:0]                  rsp_succ_ff, rsp_succ_in;
   logic [COW-1:0]                  rsp_count_ff, rsp_count_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [IW-1:0]                   rd_addr;
   logic                            key_we, succ_we;
   logic [IW-1:0]                   key_wa, succ_wa;
   logic [KW-1:0]                   key_wd, key_rd;
   logic [SW-1:0]                   succ_wd, succ_rd;
   logic signed [KW-1:0]            cmp_a, cmp_b;
   slst_pkg::cmp_res_type           cmp_res;

   logic [CW-1:0]                   count_m1;
   logic [IW-1:0]                   top_idx;
   logic [IW-1:0]                   slot_idx;
   logic [SOW-1:0]                  succ_rd_ext;
   logic                            out_free;
   logic                            load;
   logic                            idx_is_last;

   slst_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_wd),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   slst_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_succ_ram (
      .clock   (clock),
      .wr_en   (succ_we),
      .wr_addr (succ_wa),
      .wr_data (succ_wd),
      .rd_addr (rd_addr),
      .rd_data (succ_rd)
   );

   slst_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign count_m1    = count_ff - CW'(1);
   assign top_idx     = count_m1[IW-1:0];
   assign slot_idx    = count_ff[IW-1:0];
   assign succ_rd_ext = succ_rd[IW] ? {SOW{1'b1}} : SOW'(succ_rd[IW-1:0]);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign idx_is_last = (CW'(idx_ff) == count_m1);
   assign req_tready  = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      csucc_in      = csucc_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      resp_succ_in  = resp_succ_ff;
      rsp_status_in = rsp_status_ff;
      rsp_succ_in   = rsp_succ_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      load          = 1'b0;
      rd_addr       = cur_ff[IW-1:0];
      key_we        = 1'b0;
      key_wa        = cur_ff[IW-1:0];
      key_wd        = key_rd;
      succ_we       = 1'b0;
      succ_wa       = cur_ff[IW-1:0];
      succ_wd       = succ_rd;
      cmp_a         = key_rd;
      cmp_b         = key_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser;
               key_in       = req_tdata;
               cur_in       = head_ff;
               prev_in      = END_CODE;
               idx_in       = '0;
               status_in    = slst_pkg::ST_OK;
               resp_succ_in = '0;
               case (req_tuser)
                  slst_pkg::OP_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = slst_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_WRD;
                     end
                  end
                  slst_pkg::OP_DELETE: begin
                     state_in = S_WRD;
                  end
                  slst_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        resp_succ_in = {SOW{1'b1}};
                        state_in     = S_RESP;
                     end else begin
                        state_in = S_DRD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_WRD: begin
            if (cur_ff[IW]) begin
               if (op_ff == slst_pkg::OP_INSERT) begin
                  state_in = S_INS_WR;
               end else begin
                  status_in = slst_pkg::ST_NOTFOUND;
                  state_in  = S_RESP;
               end
            end else begin
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            if (op_ff == slst_pkg::OP_INSERT) begin
               cmp_a = key_ff;
               cmp_b = key_rd;
               if (!cmp_res.lt) begin
                  prev_in  = cur_ff;
                  cur_in   = succ_rd;
                  state_in = S_WRD;
               end else begin
                  state_in = S_INS_WR;
               end
            end else begin
               cmp_a = key_rd;
               cmp_b = key_ff;
               if (cmp_res.lt) begin
                  prev_in  = cur_ff;
                  cur_in   = succ_rd;
                  state_in = S_WRD;
               end else if (cmp_res.eq) begin
                  csucc_in = succ_rd;
                  state_in = S_DEL_UNL;
               end else begin
                  status_in = slst_pkg::ST_NOTFOUND;
                  state_in  = S_RESP;
               end
            end
         end
         S_INS_WR: begin
            key_we   = 1'b1;
            key_wa   = slot_idx;
            key_wd   = key_ff;
            succ_we  = 1'b1;
            succ_wa  = slot_idx;
            succ_wd  = cur_ff[IW] ? END_CODE : cur_ff;
            state_in = S_INS_LNK;
         end
         S_INS_LNK: begin
            if (prev_ff[IW]) begin
               head_in = {1'b0, slot_idx};
            end else begin
               succ_we = 1'b1;
               succ_wa = prev_ff[IW-1:0];
               succ_wd = {1'b0, slot_idx};
            end
            count_in = count_ff + CW'(1);
            state_in = S_RESP;
         end
         S_DEL_UNL: begin
            if (prev_ff[IW]) begin
               head_in = csucc_ff;
            end else begin
               succ_we = 1'b1;
               succ_wa = prev_ff[IW-1:0];
               succ_wd = csucc_ff;
            end
            state_in = (cur_ff[IW-1:0] == top_idx) ? S_DEL_FIN : S_DEL_RDT;
         end
         S_DEL_RDT: begin
            rd_addr  = top_idx;
            state_in = S_DEL_MOV;
         end
         S_DEL_MOV: begin
            rd_addr = top_idx;
            key_we  = 1'b1;
            key_wa  = cur_ff[IW-1:0];
            key_wd  = key_rd;
            succ_we = 1'b1;
            succ_wa = cur_ff[IW-1:0];
            succ_wd = succ_rd;
            if (head_ff == {1'b0, top_idx}) begin
               head_in = cur_ff;
            end
            idx_in   = '0;
            state_in = S_SC_RD;
         end
         S_SC_RD: begin
            rd_addr  = idx_ff;
            state_in = S_SC_CHK;
         end
         S_SC_CHK: begin
            rd_addr = idx_ff;
            cmp_a   = KW'(succ_rd);
            cmp_b   = KW'({1'b0, top_idx});
            if (cmp_res.eq) begin
               succ_we = 1'b1;
               succ_wa = idx_ff;
               succ_wd = cur_ff;
            end
            if (idx_ff == top_idx - IW'(1)) begin
               state_in = S_DEL_FIN;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SC_RD;
            end
         end
         S_DEL_FIN: begin
            count_in = count_m1;
            if (count_m1 == '0) begin
               head_in = END_CODE;
            end
            state_in = S_RESP;
         end
         S_DRD: begin
            rd_addr  = idx_ff;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            rd_addr = idx_ff;
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = slst_pkg::ST_OK;
               rsp_succ_in   = succ_rd_ext;
               rsp_count_in  = COW'(count_ff);
               rsp_last_in   = idx_is_last;
               if (idx_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_DRD;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = status_ff;
               rsp_succ_in   = resp_succ_ff;
               rsp_count_in  = COW'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= END_CODE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      csucc_ff      <= csucc_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      resp_succ_ff  <= resp_succ_in;
      rsp_status_ff <= rsp_status_in;
      rsp_succ_ff   <= rsp_succ_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_succ_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "sorted_list_slot_table_macros.svh"

`SLST_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
`SLST_ASSERT_IMP(a_head_matches_count, clock, reset, state_ff == S_IDLE, head_ff[IW] == !(|count_ff))
`SLST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

`default_nettype wire

// File: rtl/slst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/slst_cmp.sv
// Shared signed compare unit of the slot table sequencer.
// Depends on slst_pkg.
`default_nettype none

module slst_cmp (
   input  wire logic signed [slst_pkg::KEY_W-1:0] a,
   input  wire logic signed [slst_pkg::KEY_W-1:0] b,
   output slst_pkg::cmp_res_type                  res
);

   assign res.lt = (a < b);
   assign res.eq = (a == b);

endmodule

`default_nettype wire
